// File: src/gmr_pkg.sv
// ----------------------------------------------------------------------------
// gmr_pkg
// Shared types and constants for the group mean removal block.
// ----------------------------------------------------------------------------
package gmr_pkg;

    localparam int MOLECULE_COUNT_DEF = 256;
    localparam int REGION_COUNT_DEF   = 16;

    localparam int VSUM_W = 64;
    localparam int WSUM_W = 48;

    // Operation codes.
    localparam logic [1:0] OP_ACCUM   = 2'd0;
    localparam logic [1:0] OP_CORRECT = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    // Group kind codes.
    localparam logic [1:0] KIND_SYSTEM   = 2'd0;
    localparam logic [1:0] KIND_REGION   = 2'd1;
    localparam logic [1:0] KIND_MOLECULE = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_CONSTRAIN_REGIONS = 1'b0;
    localparam logic CFG_WEIGHTED_MODE     = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_READ  = 7'b0000010,
        ST_ACCUM = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_DONE  = 7'b0010000,
        ST_CLEAR = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

endpackage

// File: src/group_mean_removal.sv
// ----------------------------------------------------------------------------
// group_mean_removal
// Removes the group mean from per-charge values; molecule and region sums live in memories.
// ----------------------------------------------------------------------------
// Accumulate reads the group, adds to its sums, writes them back and returns to
// idle; correct reads the group and divides the value sum by the weight sum in 64
// steps of the one-bit-per-cycle restoring divider (an empty group skips the
// divider), and a new item is taken only once the previous result has been
// taken. Clear sweeps the molecule and region memories, one entry a cycle, and
// zeroes the system sums; the same sweep runs after reset before any item is
// accepted. One item is in work at a time.
module group_mean_removal #(
    parameter int MOLECULE_COUNT = gmr_pkg::MOLECULE_COUNT_DEF,
    parameter int REGION_COUNT   = gmr_pkg::REGION_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_wdata,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: op[1:0], value[33:2], weight[65:34], molecule_id[73:66],
    // molecule_constrained[74], region[79:75]
    input  logic [79:0] s_tdata,
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: corrected_value[31:0]
    output logic [31:0] m_tdata,
    // tuser: group_kind[1:0]
    output logic [1:0]  m_tuser
);

    localparam int MW = (MOLECULE_COUNT > 1) ? $clog2(MOLECULE_COUNT) : 1;
    localparam int RW = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
    localparam int VW = gmr_pkg::VSUM_W;
    localparam int WW = gmr_pkg::WSUM_W;
    localparam int CLR_W = (MOLECULE_COUNT > REGION_COUNT) ? MW + 1 : RW + 1;
    localparam int DIV_W = $clog2(VW) + 1;
    localparam int CW = (CLR_W > DIV_W) ? CLR_W : DIV_W;

    // Configuration registers.
    logic constrain_reg, weighted_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            constrain_reg <= 1'b0;
            weighted_reg  <= 1'b0;
        end else if (cfg_we) begin
            if (cfg_index == gmr_pkg::CFG_CONSTRAIN_REGIONS) constrain_reg <= cfg_wdata;
            else weighted_reg <= cfg_wdata;
        end
    end

    // Input field unpacking.
    logic [1:0]         in_op;
    logic signed [31:0] in_value;
    logic [31:0]        in_weight;
    logic [7:0]         in_mol;
    logic               in_molc;
    logic signed [4:0]  in_region;
    assign in_op     = s_tdata[1:0];
    assign in_value  = s_tdata[33:2];
    assign in_weight = s_tdata[65:34];
    assign in_mol    = s_tdata[73:66];
    assign in_molc   = s_tdata[74];
    assign in_region = s_tdata[79:75];

    gmr_pkg::state_t state_reg;
    logic [1:0]         kind_reg;
    logic [1:0]         op_reg;
    logic signed [31:0] val_reg;
    logic [31:0]        w_reg;
    logic [MW-1:0]      mol_reg;
    logic [RW-1:0]      rgn_reg;
    logic [CW-1:0]      cnt_reg;

    // Group memories.
    logic [VW-1:0] mol_v_mem [MOLECULE_COUNT];
    logic [WW-1:0] mol_w_mem [MOLECULE_COUNT];
    logic [VW-1:0] rgn_v_mem [REGION_COUNT];
    logic [WW-1:0] rgn_w_mem [REGION_COUNT];
    logic [VW-1:0] sys_v_reg, mol_v_rd, rgn_v_rd;
    logic [WW-1:0] sys_w_reg, mol_w_rd, rgn_w_rd;

    // Group selection from the incoming item.
    logic [1:0]    sel_kind;
    logic [MW-1:0] sel_mol;
    logic [RW-1:0] sel_rgn;
    always_comb begin
        sel_mol = MW'(32'(in_mol) % MOLECULE_COUNT);
        sel_rgn = RW'(32'(in_region[3:0]) % REGION_COUNT);
        if (in_molc) sel_kind = gmr_pkg::KIND_MOLECULE;
        else if (constrain_reg && !in_region[4]) sel_kind = gmr_pkg::KIND_REGION;
        else sel_kind = gmr_pkg::KIND_SYSTEM;
    end

    // Read data of the selected group.
    logic signed [VW-1:0] cur_v;
    logic [WW-1:0]        cur_w;
    always_comb begin
        case (kind_reg)
            gmr_pkg::KIND_MOLECULE: begin cur_v = mol_v_rd; cur_w = mol_w_rd; end
            gmr_pkg::KIND_REGION:   begin cur_v = rgn_v_rd; cur_w = rgn_w_rd; end
            default:                begin cur_v = sys_v_reg; cur_w = sys_w_reg; end
        endcase
    end

    // Product register and saturating sums.
    logic signed [VW-1:0] prod_reg;
    logic [31:0]          wacc;
    logic signed [VW-1:0] v_new;
    logic [WW-1:0]        w_new;
    logic signed [VW:0]   v_sum;
    logic [WW:0]          w_sum;
    assign wacc = weighted_reg ? w_reg : 32'h0001_0000;
    always_comb begin
        v_sum = {cur_v[VW-1], cur_v} + {prod_reg[VW-1], prod_reg};
        if (v_sum[VW] != v_sum[VW-1]) v_new = v_sum[VW] ? {1'b1, {(VW-1){1'b0}}}
                                                         : {1'b0, {(VW-1){1'b1}}};
        else v_new = v_sum[VW-1:0];
        w_sum = {1'b0, cur_w} + (WW + 1)'(wacc);
        w_new = w_sum[WW] ? {WW{1'b1}} : w_sum[WW-1:0];
    end

    // Divider: restoring, one quotient bit a cycle.
    logic [VW-1:0] quo_reg;
    logic [WW:0]   rem_reg;
    logic [WW-1:0] dvs_reg;
    logic          neg_reg;
    logic [WW+1:0] rem_sh;
    logic [WW+1:0] rem_tr;
    assign rem_sh = {rem_reg, quo_reg[VW-1]};
    assign rem_tr = rem_sh - {2'b00, dvs_reg};

    // Final mean clamp and result saturation.
    localparam logic [VW-1:0] MEAN_LIM = VW'(64'd1 << 34);
    logic [VW-1:0]        q_cl;
    logic signed [35:0]   mean_s;
    logic signed [36:0]   diff;
    logic [31:0]          res;
    always_comb begin
        q_cl = (quo_reg > MEAN_LIM) ? MEAN_LIM : quo_reg;
        mean_s = neg_reg ? -$signed({1'b0, q_cl[34:0]}) : $signed({1'b0, q_cl[34:0]});
        diff = 37'(val_reg) - 37'(mean_s);
        if (diff > 37'sd2147483647) res = 32'h7FFF_FFFF;
        else if (diff < -37'sd2147483648) res = 32'h8000_0000;
        else res = diff[31:0];
    end

    logic [31:0] out_data_reg;
    logic [1:0]  out_kind_reg;
    logic        out_valid_reg;

    assign s_tready = (state_reg == gmr_pkg::ST_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    // Memory write control.
    logic          mem_we;
    logic [MW-1:0] wr_mol;
    logic [RW-1:0] wr_rgn;
    logic [VW-1:0] wr_v;
    logic [WW-1:0] wr_w;
    logic          wr_mol_en, wr_rgn_en;
    always_comb begin
        mem_we = (state_reg == gmr_pkg::ST_ACCUM) || (state_reg == gmr_pkg::ST_CLEAR);
        if (state_reg == gmr_pkg::ST_CLEAR) begin
            wr_mol    = cnt_reg[MW-1:0];
            wr_rgn    = cnt_reg[RW-1:0];
            wr_v      = '0;
            wr_w      = '0;
            wr_mol_en = 32'(cnt_reg) < MOLECULE_COUNT;
            wr_rgn_en = 32'(cnt_reg) < REGION_COUNT;
        end else begin
            wr_mol    = mol_reg;
            wr_rgn    = rgn_reg;
            wr_v      = v_new;
            wr_w      = w_new;
            wr_mol_en = kind_reg == gmr_pkg::KIND_MOLECULE;
            wr_rgn_en = kind_reg == gmr_pkg::KIND_REGION;
        end
    end

    // Memories: synchronous read and write.
    always_ff @(posedge aclk) begin
        mol_v_rd <= mol_v_mem[mol_reg];
        mol_w_rd <= mol_w_mem[mol_reg];
        rgn_v_rd <= rgn_v_mem[rgn_reg];
        rgn_w_rd <= rgn_w_mem[rgn_reg];
        if (mem_we && wr_mol_en) begin
            mol_v_mem[wr_mol] <= wr_v;
            mol_w_mem[wr_mol] <= wr_w;
        end
        if (mem_we && wr_rgn_en) begin
            rgn_v_mem[wr_rgn] <= wr_v;
            rgn_w_mem[wr_rgn] <= wr_w;
        end
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= gmr_pkg::ST_CLEAR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            sys_v_reg     <= '0;
            sys_w_reg     <= '0;
            kind_reg      <= gmr_pkg::KIND_SYSTEM;
        end else begin
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                gmr_pkg::ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        op_reg   <= in_op;
                        val_reg  <= in_value;
                        w_reg    <= in_weight;
                        mol_reg  <= sel_mol;
                        rgn_reg  <= sel_rgn;
                        kind_reg <= sel_kind;
                        cnt_reg  <= '0;
                        if (in_op == gmr_pkg::OP_CLEAR) begin
                            sys_v_reg <= '0;
                            sys_w_reg <= '0;
                            state_reg <= gmr_pkg::ST_CLEAR;
                        end else if (in_op == gmr_pkg::OP_ACCUM ||
                                     in_op == gmr_pkg::OP_CORRECT) begin
                            state_reg <= gmr_pkg::ST_READ;
                        end
                    end
                end
                gmr_pkg::ST_READ: begin
                    // Memory read is in flight; form the product meanwhile.
                    prod_reg <= VW'($signed(val_reg) * $signed({1'b0, wacc}));
                    state_reg <= (op_reg == gmr_pkg::OP_ACCUM) ? gmr_pkg::ST_ACCUM
                                                               : gmr_pkg::ST_OUT;
                end
                gmr_pkg::ST_ACCUM: begin
                    if (kind_reg == gmr_pkg::KIND_SYSTEM) begin
                        sys_v_reg <= v_new;
                        sys_w_reg <= w_new;
                    end
                    state_reg <= gmr_pkg::ST_IDLE;
                end
                gmr_pkg::ST_OUT: begin
                    // Load the divider with the magnitude of the value sum.
                    neg_reg <= cur_v[VW-1];
                    quo_reg <= cur_v[VW-1] ? VW'(-cur_v) : cur_v;
                    rem_reg <= '0;
                    dvs_reg <= cur_w;
                    cnt_reg <= '0;
                    state_reg <= (cur_w == '0) ? gmr_pkg::ST_DONE : gmr_pkg::ST_DIV;
                    if (cur_w == '0) quo_reg <= '0;
                end
                gmr_pkg::ST_DIV: begin
                    if (!rem_tr[WW+1]) begin
                        rem_reg <= rem_tr[WW:0];
                        quo_reg <= {quo_reg[VW-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh[WW:0];
                        quo_reg <= {quo_reg[VW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (32'(cnt_reg) == VW - 1) state_reg <= gmr_pkg::ST_DONE;
                end
                gmr_pkg::ST_DONE: begin
                    out_data_reg  <= res;
                    out_kind_reg  <= kind_reg;
                    out_valid_reg <= 1'b1;
                    state_reg     <= gmr_pkg::ST_IDLE;
                end
                gmr_pkg::ST_CLEAR: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (32'(cnt_reg) == MOLECULE_COUNT - 1 && 32'(cnt_reg) >= REGION_COUNT - 1)
                        state_reg <= gmr_pkg::ST_IDLE;
                    else if (32'(cnt_reg) == REGION_COUNT - 1 &&
                             32'(cnt_reg) >= MOLECULE_COUNT - 1)
                        state_reg <= gmr_pkg::ST_IDLE;
                end
                default: state_reg <= gmr_pkg::ST_IDLE;
            endcase
        end
    end

    // Assertions.
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == gmr_pkg::ST_IDLE)
        else $error("ready outside idle");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gmr_pkg::ST_DIV) |-> !s_tready)
        else $error("accept during divide");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for group_mean_removal: a directed table, then random
// accumulate/correct/clear traffic across all register settings, with a
// predictor of the group sums and a queue of expected corrected values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int  MOL_N      = 256;
    localparam int  REG_N      = 16;
    localparam int  CYCLE_CAP  = 1000000;
    localparam int  DRAIN_WAIT = 100;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [4:0]  region;
        logic        mol_con;
        logic [7:0]  mol_id;
        logic [31:0] weight;
        logic [31:0] value;
        logic [1:0]  op;
    } charge_t;

    typedef struct {
        logic [31:0] corrected;
        logic [1:0]  kind;
    } corr_t;

    typedef struct {
        charge_t item;
        logic    has_exp;
        corr_t   exp;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic        cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    // Predictor state.
    logic signed [63:0] mol_vsum [MOL_N];
    logic        [47:0] mol_wsum [MOL_N];
    logic signed [63:0] reg_vsum [REG_N];
    logic        [47:0] reg_wsum [REG_N];
    logic signed [63:0] sys_vsum;
    logic        [47:0] sys_wsum;
    logic               pr_constrain;
    logic               pr_weighted;

    corr_t corrections_due [$];
    row_t  table_rows [$];
    int    fail_count;
    int    cycle_count = 0;
    int    stall_phase = 0;

    group_mean_removal dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void clear_sums();
        for (int i = 0; i < MOL_N; i++) begin
            mol_vsum[i] = '0;
            mol_wsum[i] = '0;
        end
        for (int i = 0; i < REG_N; i++) begin
            reg_vsum[i] = '0;
            reg_wsum[i] = '0;
        end
        sys_vsum = '0;
        sys_wsum = '0;
    endfunction

    function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                     logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return s[63:0];
    endfunction

    // Apply one item to the predicted sums; queue a correction when one results.
    function automatic void predict_charge(charge_t c);
        logic signed [63:0] vs, mean, prod, diff;
        logic        [47:0] ws;
        logic        [48:0] wsx;
        logic        [63:0] mag, q, w;
        logic [1:0]  kind;
        logic signed [4:0] rg;
        int          sel;
        corr_t       r;
        if (c.op == gmr_pkg::OP_CLEAR) begin
            clear_sums();
            return;
        end
        if (c.op == OP_UNUSED) return;
        rg = c.region;
        if (c.mol_con) begin
            kind = gmr_pkg::KIND_MOLECULE; sel = c.mol_id % MOL_N;
            vs = mol_vsum[sel]; ws = mol_wsum[sel];
        end else if (pr_constrain && rg >= 0) begin
            kind = gmr_pkg::KIND_REGION; sel = int'(rg) % REG_N;
            vs = reg_vsum[sel]; ws = reg_wsum[sel];
        end else begin
            kind = gmr_pkg::KIND_SYSTEM; sel = 0;
            vs = sys_vsum; ws = sys_wsum;
        end
        if (c.op == gmr_pkg::OP_ACCUM) begin
            w = pr_weighted ? {32'd0, c.weight} : 64'd65536;
            prod = $signed({{32{c.value[31]}}, c.value}) * $signed(w);
            vs = sat_add64(vs, prod);
            wsx = {1'b0, ws} + w[48:0];
            ws = wsx[48] ? 48'hFFFF_FFFF_FFFF : wsx[47:0];
            case (kind)
                gmr_pkg::KIND_MOLECULE: begin mol_vsum[sel] = vs; mol_wsum[sel] = ws; end
                gmr_pkg::KIND_REGION:   begin reg_vsum[sel] = vs; reg_wsum[sel] = ws; end
                default:                begin sys_vsum = vs; sys_wsum = ws; end
            endcase
            return;
        end
        // Mean truncates toward zero and is clamped before the subtraction.
        if (ws == 0) begin
            mean = 0;
        end else begin
            mag = vs[63] ? -vs : vs;
            q = mag / {16'd0, ws};
            if (q > 64'd1 << 34) q = 64'd1 << 34;
            mean = vs[63] ? -$signed(q) : $signed(q);
        end
        diff = $signed({{32{c.value[31]}}, c.value}) - mean;
        if (diff > 64'sh7FFF_FFFF) diff = 64'sh7FFF_FFFF;
        if (diff < -64'sh8000_0000) diff = -64'sh8000_0000;
        r.corrected = diff[31:0];
        r.kind = kind;
        corrections_due.push_back(r);
    endfunction

    // Result side: random stall pattern and comparison.
    always @(posedge aclk) begin
        corr_t e;
        stall_phase <= stall_phase + 1;
        if (stall_phase % 512 < 200) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
        if (aresetn && m_tvalid && m_tready) begin
            if (corrections_due.size() == 0) begin
                $display("%0t: unexpected result value=%h kind=%0d",
                         $time, m_tdata, m_tuser);
                fail_count++;
            end else begin
                e = corrections_due.pop_front();
                if (m_tdata !== e.corrected) begin
                    $display("%0t: corrected_value expected %h actual %h",
                             $time, e.corrected, m_tdata);
                    fail_count++;
                end
                if (m_tuser !== e.kind) begin
                    $display("%0t: group_kind expected %0d actual %0d",
                             $time, e.kind, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Send one item and wait for its transfer.
    task automatic send_charge(charge_t c);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_charge(c);
    endtask

    task automatic idle_gap(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Registers change only with the block drained.
    task automatic write_config(logic idx, logic val);
        idle_gap(0);
        @(posedge aclk);
        while (corrections_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT + MOL_N) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == gmr_pkg::CFG_CONSTRAIN_REGIONS) pr_constrain = val;
        else pr_weighted = val;
    endtask

    function automatic charge_t mk(logic [1:0] op, logic [31:0] v, logic [31:0] w,
                                   logic [7:0] m, logic mc, logic [4:0] rg);
        charge_t c;
        c.op = op; c.value = v; c.weight = w;
        c.mol_id = m; c.mol_con = mc; c.region = rg;
        return c;
    endfunction

    function automatic void add_row(charge_t c, logic he, logic [31:0] ev,
                                    logic [1:0] ek);
        row_t r;
        r.item = c; r.has_exp = he;
        r.exp.corrected = ev; r.exp.kind = ek;
        table_rows.push_back(r);
    endfunction

    // Random charge; mostly small groups so sums build up, sometimes extremes.
    function automatic charge_t random_charge();
        charge_t c;
        int k;
        k = $urandom_range(0, 99);
        c.op = (k < 55) ? gmr_pkg::OP_ACCUM : (k < 95) ? gmr_pkg::OP_CORRECT
             : (k < 97) ? gmr_pkg::OP_CLEAR : OP_UNUSED;
        case ($urandom_range(0, 3))
            0: c.value = $urandom;
            1: c.value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: c.value = $signed($urandom_range(0, 2000000)) - 1000000;
        endcase
        c.weight = ($urandom_range(0, 4) == 0) ? $urandom
                 : $urandom_range(0, 1 << 20);
        c.mol_id = 8'(($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 3));
        c.mol_con = $urandom_range(0, 2) == 0;
        c.region = 5'($urandom);
        return c;
    endfunction

    initial begin
        charge_t c;
        corr_t   e;
        int      burst;
        fail_count = 0;
        aresetn = 1'b0; cfg_we = 1'b0; cfg_index = 1'b0; cfg_wdata = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0;
        pr_constrain = 1'b0; pr_weighted = 1'b0;
        clear_sums();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty groups return the value unchanged, then sums, clear.
        add_row(mk(gmr_pkg::OP_CORRECT, 32'h7FFF_FFFF, 0, 0, 0, 0), 1, 32'h7FFF_FFFF,
                gmr_pkg::KIND_SYSTEM);
        add_row(mk(gmr_pkg::OP_CORRECT, 32'h8000_0000, 0, 255, 1, 0), 1, 32'h8000_0000,
                gmr_pkg::KIND_MOLECULE);
        add_row(mk(gmr_pkg::OP_CORRECT, 32'h0001_0000, 0, 3, 0, 5'h1F), 1, 32'h0001_0000,
                gmr_pkg::KIND_SYSTEM);
        add_row(mk(gmr_pkg::OP_ACCUM, 32'h0002_0000, 32'hFFFF_FFFF, 7, 1, 0), 0, 0, 0);
        add_row(mk(gmr_pkg::OP_CORRECT, 32'h0005_0000, 0, 7, 1, 0), 1, 32'h0003_0000,
                gmr_pkg::KIND_MOLECULE);
        add_row(mk(gmr_pkg::OP_ACCUM, 32'h8000_0000, 0, 0, 0, 15), 0, 0, 0);
        add_row(mk(gmr_pkg::OP_CORRECT, 32'h7FFF_FFFF, 0, 0, 0, 15), 1, 32'h7FFF_FFFF,
                gmr_pkg::KIND_SYSTEM);
        add_row(mk(OP_UNUSED, 32'h1234_5678, 0, 7, 1, 0), 0, 0, 0);
        add_row(mk(gmr_pkg::OP_CORRECT, 32'h0005_0000, 0, 7, 1, 0), 1, 32'h0003_0000,
                gmr_pkg::KIND_MOLECULE);
        add_row(mk(gmr_pkg::OP_CLEAR, 0, 0, 0, 0, 0), 0, 0, 0);
        add_row(mk(gmr_pkg::OP_CORRECT, 32'h0005_0000, 0, 7, 1, 0), 1, 32'h0005_0000,
                gmr_pkg::KIND_MOLECULE);
        foreach (table_rows[i]) begin
            send_charge(table_rows[i].item);
            if (table_rows[i].has_exp) begin
                e = corrections_due.pop_back();
                if (e.corrected !== table_rows[i].exp.corrected ||
                    e.kind !== table_rows[i].exp.kind) begin
                    $display("%0t: table row %0d expected %h/%0d, predictor %h/%0d",
                             $time, i, table_rows[i].exp.corrected,
                             table_rows[i].exp.kind, e.corrected, e.kind);
                    fail_count++;
                end
                corrections_due.push_back(table_rows[i].exp);
            end
        end

        // Weighted region mode over all group kinds; the value sum saturates.
        write_config(gmr_pkg::CFG_CONSTRAIN_REGIONS, 1'b1);
        write_config(gmr_pkg::CFG_WEIGHTED_MODE, 1'b1);
        send_charge(mk(gmr_pkg::OP_CORRECT, 32'h0000_1000, 0, 0, 0, 5'd15));
        for (int i = 0; i < 4; i++)
            send_charge(mk(gmr_pkg::OP_ACCUM, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 5'd2));
        send_charge(mk(gmr_pkg::OP_CORRECT, 32'h8000_0000, 0, 0, 0, 5'd2));
        send_charge(mk(gmr_pkg::OP_ACCUM, 32'h8000_0000, 32'd1, 9, 1, 5'h1F));
        send_charge(mk(gmr_pkg::OP_CORRECT, 32'h7FFF_FFFF, 0, 9, 1, 5'h1F));
        send_charge(mk(gmr_pkg::OP_ACCUM, 32'h0001_0000, 32'd0, 0, 0, 5'h1F));
        send_charge(mk(gmr_pkg::OP_CORRECT, 32'h0001_0000, 0, 0, 0, 5'h1F));

        // Random phases over every register setting.
        for (int ph = 0; ph < 8; ph++) begin
            write_config(gmr_pkg::CFG_CONSTRAIN_REGIONS, ph[0]);
            write_config(gmr_pkg::CFG_WEIGHTED_MODE, ph[1]);
            for (int n = 0; n < 210; ) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < 210; b++, n++) begin
                    c = random_charge();
                    send_charge(c);
                end
                if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 80));
            end
        end

        idle_gap(0);
        while (corrections_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (fail_count == 0 && corrections_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
